/* rtl/rtfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfe_pkg
// Shared constants, types and tables of the ray to field edge distance core.
// ----------------------------------------------------------------------------
package rtfe_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int DIST_BITS    = 20;
  localparam int CORDIC_STEPS = 16;

  // cordic datapath: q2.30 values with guard bits, angle 2^32 per turn
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int RW = ANGLE_BITS - 2;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
  localparam logic [DIST_BITS-1:0] DIST_SAT = {DIST_BITS{1'b1}};
  localparam logic [16:0] Q15_ONE = 17'd32768;

  // quadrant codes
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // per-transaction data that rides alongside the cordic
  typedef struct packed {
    logic        hx;
    logic        hy;
    logic        swap;
    logic [15:0] nx;
    logic [15:0] ny;
  } side_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_turn(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'd0:    v = 32'h20000000;
      4'd1:    v = 32'h12E4051E;
      4'd2:    v = 32'h09FB385B;
      4'd3:    v = 32'h051111D4;
      4'd4:    v = 32'h028B0D43;
      4'd5:    v = 32'h0145D7E1;
      4'd6:    v = 32'h00A2F61E;
      4'd7:    v = 32'h00517C55;
      4'd8:    v = 32'h0028BE53;
      4'd9:    v = 32'h00145F2F;
      4'd10:   v = 32'h000A2F98;
      4'd11:   v = 32'h000517CC;
      4'd12:   v = 32'h00028BE6;
      4'd13:   v = 32'h000145F3;
      4'd14:   v = 32'h0000A2F9;
      4'd15:   v = 32'h0000517C;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/rtfe_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfe_cordic
// Rotation-mode cordic, one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
module rtfe_cordic import rtfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [RW-1:0]        in_r,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output side_t                out_side
);

  logic                 v_r    [CORDIC_STEPS];
  logic signed [CW-1:0] x_r    [CORDIC_STEPS];
  logic signed [CW-1:0] y_r    [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [CORDIC_STEPS];
  side_t                side_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                 v_in;
    logic signed [CW-1:0] x_in, y_in, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_in, z_nxt, at;
    side_t                s_in;

    // stage input select
    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = ZW'({in_r, {(32 - ANGLE_BITS){1'b0}}});
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = v_r[i-1];
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
      assign s_in = side_r[i-1];
    end

    // one micro-rotation
    always_comb begin
      at = ZW'(atan_turn(4'(i)));
      if (!z_in[ZW-1]) begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - at;
      end else begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      x_r[i]    <= x_nxt;
      y_r[i]    <= y_nxt;
      z_r[i]    <= z_nxt;
      side_r[i] <= s_in;
    end
  end

  assign out_valid = v_r[CORDIC_STEPS-1];
  assign out_x     = x_r[CORDIC_STEPS-1];
  assign out_y     = y_r[CORDIC_STEPS-1];
  assign out_side  = side_r[CORDIC_STEPS-1];

endmodule

/* rtl/rtfe_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfe_div
// Pipelined restoring divider for (num << 15) / mag, one quotient bit per
// stage, saturating at the distance maximum.
// ----------------------------------------------------------------------------
module rtfe_div import rtfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_bound,
  input  logic [15:0]          in_num,
  input  logic [15:0]          in_mag,
  output logic                 out_valid,
  output logic [DIST_BITS-1:0] out_dist
);

  localparam int DW = DIST_BITS + 16;

  logic [DW-1:0] dvd;
  logic [16:0]   rem0;
  logic          sat0;

  logic                 v_r   [DIST_BITS];
  logic                 sat_r [DIST_BITS];
  logic [16:0]          rem_r [DIST_BITS];
  logic [DW-1:0]        dvd_r [DIST_BITS];
  logic [15:0]          mag_r [DIST_BITS];
  logic [DIST_BITS-1:0] quo_r [DIST_BITS];

  // high part of the dividend; quotient overflows when it reaches mag
  assign dvd  = DW'({in_num, 15'd0});
  assign rem0 = 17'(dvd >> DIST_BITS);
  assign sat0 = !in_bound || (in_mag == 16'd0) || (rem0 >= {1'b0, in_mag});

  for (genvar i = 0; i < DIST_BITS; i++) begin : g_stage
    logic                 v_in, sat_in;
    logic [16:0]          rem_in, rem_nxt;
    logic [17:0]          trial;
    logic [DW-1:0]        dvd_in;
    logic [15:0]          mag_in;
    logic [DIST_BITS-1:0] quo_in;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign sat_in = sat0;
      assign rem_in = rem0;
      assign dvd_in = dvd;
      assign mag_in = in_mag;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign sat_in = sat_r[i-1];
      assign rem_in = rem_r[i-1];
      assign dvd_in = dvd_r[i-1];
      assign mag_in = mag_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // trial subtract of the next dividend bit
    always_comb begin
      trial   = {rem_in, dvd_in[DIST_BITS-1-i]};
      rem_nxt = 17'(trial);
      if (trial >= {2'b00, mag_in}) begin
        rem_nxt = 17'(trial - {2'b00, mag_in});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_in;
      end
      sat_r[i] <= sat_in;
      rem_r[i] <= rem_nxt;
      dvd_r[i] <= dvd_in;
      mag_r[i] <= mag_in;
      quo_r[i] <= {quo_in[DIST_BITS-2:0], (trial >= {2'b00, mag_in})};
    end
  end

  assign out_valid = v_r[DIST_BITS-1];
  assign out_dist  = sat_r[DIST_BITS-1] ? DIST_SAT : quo_r[DIST_BITS-1];

endmodule

/* rtl/ray_to_field_edge_distance_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_to_field_edge_distance_core
// Distance along a heading from a robot position to the nearest edge of a
// rectangular field, from a pipelined cordic and two pipelined dividers.
//
//   channel   direction  ports
//   input     in         start, busy, in_pos_x, in_pos_y, in_heading
//   result    out        out_valid, out_edge_distance
//   config    in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// the pipeline has 1 input stage, 16 cordic stages, 1 magnitude stage,
// 20 divider stages and 1 output stage; one transaction is taken every cycle.
// busy stays low; the result is a one-cycle strobe and cannot be stalled.
// reset clears the valid bits and loads field 3000 x 2000.
// ----------------------------------------------------------------------------
module ray_to_field_edge_distance_core import rtfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [15:0]          in_pos_x,
  input  logic [15:0]          in_pos_y,
  input  logic [15:0]          in_heading,
  output logic                 out_valid,
  output logic [DIST_BITS-1:0] out_edge_distance,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  logic [15:0] field_width_r, field_height_r;
  logic        cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r  <= 16'd3000;
      field_height_r <= 16'd2000;
    end else if (cfg_wr) begin
      if (paddr == ADDR_WIDTH)  field_width_r  <= pwdata[15:0];
      if (paddr == ADDR_HEIGHT) field_height_r <= pwdata[15:0];
    end
  end

  always_comb begin
    case (paddr)
      ADDR_WIDTH:  prdata = {16'd0, field_width_r};
      ADDR_HEIGHT: prdata = {16'd0, field_height_r};
      default:     prdata = '0;
    endcase
  end

  // input stage: quadrant split and wall numerators
  quad_t          q;
  logic [RW-1:0]  r;
  logic           rnz;
  logic [16:0]    dfx, dfy;
  side_t          side_nxt;
  logic           s0_valid_r;
  logic [RW-1:0]  s0_r_r;
  side_t          s0_side_r;

  assign busy = 1'b0;
  assign q    = quad_t'(in_heading[ANGLE_BITS-1 -: 2]);
  assign r    = in_heading[RW-1:0];
  assign rnz  = (r != '0);
  assign dfx  = {1'b0, field_width_r} - {1'b0, in_pos_x};
  assign dfy  = {1'b0, field_height_r} - {1'b0, in_pos_y};

  always_comb begin
    side_nxt      = '0;
    side_nxt.swap = q[0];
    // x wall
    if (q == QUAD_0 || (q == QUAD_3 && rnz)) begin
      side_nxt.hx = 1'b1;
      side_nxt.nx = dfx[16] ? 16'd0 : dfx[15:0];
    end else if ((q == QUAD_1 && rnz) || q == QUAD_2) begin
      side_nxt.hx = 1'b1;
      side_nxt.nx = in_pos_x;
    end
    // y wall
    if ((q == QUAD_0 && rnz) || q == QUAD_1) begin
      side_nxt.hy = 1'b1;
      side_nxt.ny = dfy[16] ? 16'd0 : dfy[15:0];
    end else if ((q == QUAD_2 && rnz) || q == QUAD_3) begin
      side_nxt.hy = 1'b1;
      side_nxt.ny = in_pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
    s0_r_r    <= r;
    s0_side_r <= side_nxt;
  end

  // cordic pipeline
  logic                 c_valid;
  logic signed [CW-1:0] c_x, c_y;
  side_t                c_side;

  rtfe_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_valid_r),
    .in_r      (s0_r_r),
    .in_side   (s0_side_r),
    .out_valid (c_valid),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_side  (c_side)
  );

  // magnitude stage: round to q1.15 and map by quadrant
  function automatic logic [15:0] to_q15(input logic signed [CW-1:0] v);
    logic [CW-1:0] s;
    logic [18:0]   m;
    s = v[CW-1] ? '0 : v + CW'(16384);
    m = 19'(s >> 15);
    return (m > 19'(Q15_ONE)) ? Q15_ONE[15:0] : m[15:0];
  endfunction

  logic [15:0] cr, sr;
  logic        m_valid_r;
  logic [15:0] cmag_r, smag_r;
  side_t       m_side_r;

  assign cr = to_q15(c_x);
  assign sr = to_q15(c_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= c_valid;
    end
    cmag_r   <= c_side.swap ? sr : cr;
    smag_r   <= c_side.swap ? cr : sr;
    m_side_r <= c_side;
  end

  // per-axis dividers
  logic                 dx_valid, dy_valid;
  logic [DIST_BITS-1:0] dx, dy;

  rtfe_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid_r),
    .in_bound  (m_side_r.hx),
    .in_num    (m_side_r.nx),
    .in_mag    (cmag_r),
    .out_valid (dx_valid),
    .out_dist  (dx)
  );

  rtfe_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid_r),
    .in_bound  (m_side_r.hy),
    .in_num    (m_side_r.ny),
    .in_mag    (smag_r),
    .out_valid (dy_valid),
    .out_dist  (dy)
  );

  // nearest wall and output register
  logic                 out_valid_r;
  logic [DIST_BITS-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dx_valid;
    end
    out_dist_r <= (dx < dy) ? dx : dy;
  end

  assign out_valid         = out_valid_r;
  assign out_edge_distance = out_dist_r;

  // checks
  a_one_wall: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r |-> (s0_side_r.hx || s0_side_r.hy))
    else $error("transaction with no wall bound");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r |-> (cmag_r <= Q15_ONE[15:0] && smag_r <= Q15_ONE[15:0]))
    else $error("q1.15 magnitude above one");

  a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
    dx_valid == dy_valid)
    else $error("divider pipelines out of step");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr == ADDR_WIDTH) |=> field_width_r == $past(pwdata[15:0]))
    else $error("field width write lost");

endmodule

/* bench/rtfe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfe_checker
// Watches the query, config and distance channels, models the edge distance of each
// accepted query and compares it with the strobed distance, oldest first.
// ----------------------------------------------------------------------------
module rtfe_checker import rtfe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [15:0]          in_pos_x,
  input  logic [15:0]          in_pos_y,
  input  logic [15:0]          in_heading,
  input  logic                 out_valid,
  input  logic [DIST_BITS-1:0] out_edge_distance,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  output int                   fail_count,
  output int                   pending
);

  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  logic [15:0] width_mm;
  logic [15:0] height_mm;
  logic [DIST_BITS-1:0] dist_q[$];

  assign pending = dist_q.size();

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q15_mag(longint v);
    longint m;
    if (v < 0) v = 0;
    m = (v + 16384) >> 15;
    return (m > 32768) ? 32768 : m;
  endfunction

  function automatic longint axis_dist(longint num, longint mag);
    longint d;
    if (mag == 0) return longint'(DIST_SAT);
    if (num < 0) num = 0;
    d = (num <<< 15) / mag;
    return (d > longint'(DIST_SAT)) ? longint'(DIST_SAT) : d;
  endfunction

  // edge distance for one query against the current field size
  function automatic logic [DIST_BITS-1:0] edge_distance(
      logic [15:0] px, logic [15:0] py, logic [15:0] hd);
    longint x, y, z, dx, dy, cr, sr, cm, sm, bx, by;
    quad_t q;
    logic [RW-1:0] r;
    x = 652032874;
    y = 0;
    q = quad_t'(hd[ANGLE_BITS-1 -: 2]);
    r = hd[RW-1:0];
    z = longint'(r) <<< (32 - ANGLE_BITS);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(4'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(4'(i)));
      end
    end
    cr = q15_mag(x);
    sr = q15_mag(y);
    cm = (q == QUAD_0 || q == QUAD_2) ? cr : sr;
    sm = (q == QUAD_0 || q == QUAD_2) ? sr : cr;
    bx = longint'(DIST_SAT);
    by = longint'(DIST_SAT);
    if (q == QUAD_0 || (q == QUAD_3 && r != 0))
      bx = axis_dist(longint'(width_mm) - longint'(px), cm);
    else if ((q == QUAD_1 && r != 0) || q == QUAD_2)
      bx = axis_dist(longint'(px), cm);
    if ((q == QUAD_0 && r != 0) || q == QUAD_1)
      by = axis_dist(longint'(height_mm) - longint'(py), sm);
    else if ((q == QUAD_2 && r != 0) || q == QUAD_3)
      by = axis_dist(longint'(py), sm);
    return DIST_BITS'((bx < by) ? bx : by);
  endfunction

  // track register writes, predict and compare
  always @(posedge clk) begin
    if (!rst_n) begin
      width_mm   <= 16'd3000;
      height_mm  <= 16'd2000;
      fail_count <= 0;
      dist_q.delete();
    end else begin
      if (out_valid) begin
        if (dist_q.size() == 0) begin
          if (fail_count < 10)
            $display("mismatch: unexpected distance %0d", out_edge_distance);
          fail_count <= fail_count + 1;
        end else begin
          if (dist_q[0] !== out_edge_distance) begin
            if (fail_count < 10)
              $display("mismatch: edge_distance expected %0d actual %0d",
                       dist_q[0], out_edge_distance);
            fail_count <= fail_count + 1;
          end
          void'(dist_q.pop_front());
        end
      end
      if (start && !busy)
        dist_q.push_back(edge_distance(in_pos_x, in_pos_y, in_heading));
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_WIDTH:  width_mm  <= pwdata[15:0];
          ADDR_HEIGHT: height_mm <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* bench/tb_ray_to_field_edge_distance_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_to_field_edge_distance_core
// Drives pose queries and field size writes into the edge distance core
// with random gaps; the checker predicts every distance and counts errors.
// ----------------------------------------------------------------------------
module tb_ray_to_field_edge_distance_core;
  import rtfe_pkg::*;

  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;
  localparam int LATENCY = 39;
  localparam int MAX_CYCLES = 400000;

  logic clk, rst_n, start, busy, out_valid, psel, penable, pwrite, pready;
  logic [15:0] in_pos_x, in_pos_y, in_heading;
  logic [DIST_BITS-1:0] out_edge_distance;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending, cycles, sent;

  ray_to_field_edge_distance_core dut (.*);

  rtfe_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait for every outstanding distance, then let the pipe drain
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one query transaction; start stays high into the next one when back to back
  task automatic send_query(logic [15:0] px, logic [15:0] py, logic [15:0] hd);
    start <= 1'b1; in_pos_x <= px; in_pos_y <= py; in_heading <= hd;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic random_query(logic [15:0] w, logic [15:0] h);
    logic [15:0] px, py, hd;
    int k;
    k = $urandom_range(0, 9);
    px = (k < 7 && w != 0) ? 16'($urandom_range(0, w)) : 16'($urandom);
    py = (k < 7 && h != 0) ? 16'($urandom_range(0, h)) : 16'($urandom);
    hd = 16'($urandom);
    if (k == 9) hd = {hd[15:14], 14'd0} | 16'($urandom_range(0, 3));
    // like send_query, this leaves start high; the gap task lowers it for a gap
    start <= 1'b1; in_pos_x <= px; in_pos_y <= py; in_heading <= hd;
    do @(posedge clk); while (busy);
    sent++;
    idle_gap();
  endtask

  logic [15:0] widths[5], heights[5];

  initial begin
    rst_n = 1'b0; start = 1'b0; in_pos_x = '0; in_pos_y = '0; in_heading = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycles = 0; sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: axis headings, extremes, positions outside the field
    send_query(16'd1500, 16'd1000, 16'h0000);
    send_query(16'd1500, 16'd1000, 16'h4000);
    send_query(16'd1500, 16'd1000, 16'h8000);
    send_query(16'd1500, 16'd1000, 16'hC000);
    send_query(16'd0, 16'd0, 16'h0001);
    send_query(16'd0, 16'd0, 16'h3FFF);
    send_query(16'd3000, 16'd2000, 16'h2000);
    send_query(16'd3000, 16'd2000, 16'hA000);
    send_query(16'hFFFF, 16'hFFFF, 16'h2000);
    send_query(16'hFFFF, 16'd500, 16'h0000);
    send_query(16'd100, 16'hFFFF, 16'h4001);
    send_query(16'd1, 16'd1, 16'hFFFF);
    send_query(16'd2999, 16'd1999, 16'h7FFF);
    send_query(16'd1500, 16'd1, 16'hBFFF);
    send_query(16'd1500, 16'd1000, 16'hC001);
    send_query(16'd1500, 16'd1000, 16'h8001);
    send_query(16'hAAAA, 16'h5555, 16'h5555);
    send_query(16'h5555, 16'hAAAA, 16'hAAAA);
    drain();

    widths  = '{16'hFFFF, 16'd0, 16'd1, 16'd3000, 16'($urandom)};
    heights = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd2000, 16'($urandom)};
    for (int p = 0; p < 5; p++) begin
      reg_write(ADDR_WIDTH, {16'($urandom), widths[p]});
      reg_write(ADDR_HEIGHT, {16'($urandom), heights[p]});
      for (int i = 0; i < 320; i++) begin
        random_query(widths[p], heights[p]);
        // sender holds off until every distance is back
        if (p == 2 && i == 100) drain();
      end
      drain();
    end

    $display("covered %0d queries over five field sizes incl. zero and full range", sent);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
